FILE: hdl/cnc_pkg.sv
// Shared types, codes and constants of the common neighbor counter.
package cnc_pkg;

    localparam int unsigned MAX_VERTICES_DEF = 1024;
    localparam int unsigned MAX_EDGES_DEF    = 8192;

    localparam int unsigned ACTION_W   = 2;
    localparam int unsigned INDEX_W    = 13;
    localparam int unsigned VALUE_W    = 14;
    localparam int unsigned VERTEX_W   = 10;
    localparam int unsigned COUNT_W    = 11;
    localparam int unsigned VCOUNT_W   = 11;

    localparam logic [COUNT_W-1:0] COUNT_SAT = {COUNT_W{1'b1}};

    typedef enum logic [ACTION_W-1:0] {
        ACT_ROW_START = 2'd0,
        ACT_NEIGHBOR  = 2'd1,
        ACT_COUNT     = 2'd2,
        ACT_NOP       = 2'd3
    } action_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [INDEX_W-1:0]  table_index;
        logic [VALUE_W-1:0]  table_value;
        logic [VERTEX_W-1:0] vertex_a;
        logic [VERTEX_W-1:0] vertex_b;
    } in_item_t;

    typedef struct packed {
        logic [COUNT_W-1:0] common_count;
        logic               range_error;
    } out_item_t;

    // Query launch from the front end to the list walker
    typedef struct packed {
        logic start;
        logic range_err;
    } walk_ctl_t;

    // Walker status back to the front end
    typedef struct packed {
        logic idle;
        logic done;
    } walk_sts_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROW_LO,
        S_ROW_HI,
        S_MERGE,
        S_DONE
    } walk_state_t;

endpackage

FILE: hdl/cnc_ram.sv
// Generic synchronous RAM: one write port, two registered read ports.
module cnc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_a_reg <= mem_reg[raddr_a];
        rdata_b_reg <= mem_reg[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

FILE: hdl/cnc_walk.sv
// Query sequencer: fetches row bounds, then merge-walks both neighbor lists.
module cnc_walk #(
    parameter int unsigned MAX_VERTICES = cnc_pkg::MAX_VERTICES_DEF,
    parameter int unsigned MAX_EDGES    = cnc_pkg::MAX_EDGES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  cnc_pkg::walk_ctl_t                 ctl,
    input  logic [cnc_pkg::VERTEX_W-1:0]       vertex_a,
    input  logic [cnc_pkg::VERTEX_W-1:0]       vertex_b,
    input  logic                               out_free,
    input  logic [cnc_pkg::VALUE_W-1:0]        row_rdata_a,
    input  logic [cnc_pkg::VALUE_W-1:0]        row_rdata_b,
    input  logic [cnc_pkg::VERTEX_W-1:0]       nb_rdata_a,
    input  logic [cnc_pkg::VERTEX_W-1:0]       nb_rdata_b,
    output logic [$clog2(MAX_VERTICES+1)-1:0]  row_raddr_a,
    output logic [$clog2(MAX_VERTICES+1)-1:0]  row_raddr_b,
    output logic [$clog2(MAX_EDGES)-1:0]       nb_raddr_a,
    output logic [$clog2(MAX_EDGES)-1:0]       nb_raddr_b,
    output cnc_pkg::walk_sts_t                 sts,
    output cnc_pkg::out_item_t                 result
);

    localparam int unsigned RA = $clog2(MAX_VERTICES + 1);
    localparam int unsigned NA = $clog2(MAX_EDGES);
    localparam int unsigned EW = $clog2(MAX_EDGES + 1);
    localparam logic [31:0] EDGE_LIMIT = 32'(MAX_EDGES);

    cnc_pkg::walk_state_t state_reg, state_next;

    logic [cnc_pkg::VERTEX_W-1:0] va_reg, vb_reg;
    logic [EW-1:0]                pa_reg, pb_reg, ea_reg, eb_reg;
    logic [cnc_pkg::COUNT_W-1:0]  cnt_reg;
    logic                         err_reg;

    logic          run;
    logic          heads_eq;
    logic          heads_lt;
    logic [EW-1:0] pa_adv, pb_adv;

    // Clamp a stored row offset to the end of the neighbor table
    function automatic logic [EW-1:0] clamp_edge(input logic [cnc_pkg::VALUE_W-1:0] v);
        if (32'(v) > EDGE_LIMIT)
        begin
            return EW'(EDGE_LIMIT);
        end
        return EW'(v);
    endfunction

    assign run      = (pa_reg < ea_reg) && (pb_reg < eb_reg);
    assign heads_eq = (nb_rdata_a == nb_rdata_b);
    assign heads_lt = (nb_rdata_a < nb_rdata_b);
    assign pa_adv   = pa_reg + EW'(heads_eq || heads_lt);
    assign pb_adv   = pb_reg + EW'(heads_eq || !heads_lt);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cnc_pkg::S_IDLE:
            begin
                if (ctl.start)
                begin
                    state_next = ctl.range_err ? cnc_pkg::S_DONE : cnc_pkg::S_ROW_LO;
                end
            end
            cnc_pkg::S_ROW_LO: state_next = cnc_pkg::S_ROW_HI;
            cnc_pkg::S_ROW_HI: state_next = cnc_pkg::S_MERGE;
            cnc_pkg::S_MERGE:
            begin
                if (!run)
                begin
                    state_next = cnc_pkg::S_DONE;
                end
            end
            cnc_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    state_next = cnc_pkg::S_IDLE;
                end
            end
            default: state_next = cnc_pkg::S_IDLE;
        endcase
    end

    // Outputs: memory addresses and status
    always_comb
    begin
        row_raddr_a = RA'(va_reg) + RA'(1);
        row_raddr_b = RA'(vb_reg) + RA'(1);
        nb_raddr_a  = NA'(pa_reg);
        nb_raddr_b  = NA'(pb_reg);
        sts.idle    = 1'b0;
        sts.done    = 1'b0;
        unique case (state_reg)
            cnc_pkg::S_IDLE:
            begin
                sts.idle    = 1'b1;
                row_raddr_a = RA'(vertex_a);
                row_raddr_b = RA'(vertex_b);
            end
            cnc_pkg::S_ROW_LO: ;
            cnc_pkg::S_ROW_HI: ;
            cnc_pkg::S_MERGE:
            begin
                nb_raddr_a = NA'(pa_adv);
                nb_raddr_b = NA'(pb_adv);
            end
            cnc_pkg::S_DONE: sts.done = 1'b1;
            default: ;
        endcase
    end

    assign result.common_count = cnt_reg;
    assign result.range_error  = err_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cnc_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Datapath: pointers, bounds and the running count
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            cnc_pkg::S_IDLE:
            begin
                va_reg  <= vertex_a;
                vb_reg  <= vertex_b;
                cnt_reg <= '0;
                err_reg <= ctl.range_err;
            end
            cnc_pkg::S_ROW_LO:
            begin
                pa_reg <= clamp_edge(row_rdata_a);
                pb_reg <= clamp_edge(row_rdata_b);
            end
            cnc_pkg::S_ROW_HI:
            begin
                ea_reg <= clamp_edge(row_rdata_a);
                eb_reg <= clamp_edge(row_rdata_b);
            end
            cnc_pkg::S_MERGE:
            begin
                if (run)
                begin
                    pa_reg <= pa_adv;
                    pb_reg <= pb_adv;
                    if (heads_eq && (cnt_reg != cnc_pkg::COUNT_SAT))
                    begin
                        cnt_reg <= cnt_reg + cnc_pkg::COUNT_W'(1);
                    end
                end
            end
            cnc_pkg::S_DONE: ;
            default: ;
        endcase
    end

endmodule

FILE: hdl/csr_common_neighbor_counter.sv
// Top level of the common neighbor counter: memories, front end and result register.
//
//   Input channel (in_valid / in_ready / in_data) carries three kinds of item:
//   a row start write, a neighbor write, or a count query for two vertices.
//   Writes take effect at the accept edge and produce no result; writes past
//   a table's depth are dropped. A query yields exactly one result item on
//   the output channel (out_valid / out_ready / out_data).
//   cfg_we / cfg_wdata load vertex_count; write it only while the block is idle.
//
//   Write items are accepted back to back while the walker is idle. A query
//   walks both lists in S merge steps, at most the sum of the two
//   degrees; the merge step rate is set by the neighbor memory, read at both
//   list heads once per cycle. The S_ROW_LO and S_ROW_HI states first fetch
//   the row bounds from the row start memory. A query out of range skips the
//   walk and returns a zero count with range_error set.
//
// Reset clears the sequencer, the output valid flag and vertex_count; the table
// contents stay undefined until written. When the receiver stalls, the result
// waits in the output register while further write items are still accepted;
// a finished query holds in its done state until that register frees up.
module csr_common_neighbor_counter #(
    parameter int unsigned MAX_VERTICES = cnc_pkg::MAX_VERTICES_DEF,
    parameter int unsigned MAX_EDGES    = cnc_pkg::MAX_EDGES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  cnc_pkg::in_item_t             in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output cnc_pkg::out_item_t            out_data,
    input  logic                          cfg_we,
    input  logic [cnc_pkg::VCOUNT_W-1:0]  cfg_wdata
);

    localparam int unsigned RA = $clog2(MAX_VERTICES + 1);
    localparam int unsigned NA = $clog2(MAX_EDGES);

    logic [cnc_pkg::VCOUNT_W-1:0] vertex_count_reg;
    logic                         out_valid_reg;
    cnc_pkg::out_item_t           out_data_reg;

    logic                   in_acc;
    logic                   row_we, nb_we;
    logic                   out_free;
    cnc_pkg::walk_ctl_t     ctl;
    cnc_pkg::walk_sts_t     sts;
    cnc_pkg::out_item_t     result;

    logic [RA-1:0]                row_raddr_a, row_raddr_b;
    logic [NA-1:0]                nb_raddr_a, nb_raddr_b;
    logic [cnc_pkg::VALUE_W-1:0]  row_rdata_a, row_rdata_b;
    logic [cnc_pkg::VERTEX_W-1:0] nb_rdata_a, nb_rdata_b;

    // Accept only while the walker is idle; in_ready does not look at the output
    assign in_ready = sts.idle;
    assign in_acc   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // Decode write items, dropping indexes past each table
    assign row_we = in_acc && (in_data.action == cnc_pkg::ACT_ROW_START)
                    && (32'(in_data.table_index) <= 32'(MAX_VERTICES));
    assign nb_we  = in_acc && (in_data.action == cnc_pkg::ACT_NEIGHBOR)
                    && (32'(in_data.table_index) < 32'(MAX_EDGES));

    // Launch a query; flag vertices past the configured or built-in limit
    assign ctl.start     = in_acc && (in_data.action == cnc_pkg::ACT_COUNT);
    assign ctl.range_err =
        ({1'b0, in_data.vertex_a} >= vertex_count_reg) ||
        ({1'b0, in_data.vertex_b} >= vertex_count_reg) ||
        (32'(in_data.vertex_a) >= 32'(MAX_VERTICES)) ||
        (32'(in_data.vertex_b) >= 32'(MAX_VERTICES));

    cnc_ram #(
        .WIDTH (cnc_pkg::VALUE_W),
        .DEPTH (MAX_VERTICES + 1)
    ) u_row_ram (
        .clk     (clk),
        .we      (row_we),
        .waddr   (RA'(in_data.table_index)),
        .wdata   (in_data.table_value),
        .raddr_a (row_raddr_a),
        .raddr_b (row_raddr_b),
        .rdata_a (row_rdata_a),
        .rdata_b (row_rdata_b)
    );

    cnc_ram #(
        .WIDTH (cnc_pkg::VERTEX_W),
        .DEPTH (MAX_EDGES)
    ) u_nb_ram (
        .clk     (clk),
        .we      (nb_we),
        .waddr   (NA'(in_data.table_index)),
        .wdata   (in_data.table_value[cnc_pkg::VERTEX_W-1:0]),
        .raddr_a (nb_raddr_a),
        .raddr_b (nb_raddr_b),
        .rdata_a (nb_rdata_a),
        .rdata_b (nb_rdata_b)
    );

    cnc_walk #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_EDGES    (MAX_EDGES)
    ) u_walk (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .vertex_a    (in_data.vertex_a),
        .vertex_b    (in_data.vertex_b),
        .out_free    (out_free),
        .row_rdata_a (row_rdata_a),
        .row_rdata_b (row_rdata_b),
        .nb_rdata_a  (nb_rdata_a),
        .nb_rdata_b  (nb_rdata_b),
        .row_raddr_a (row_raddr_a),
        .row_raddr_b (row_raddr_b),
        .nb_raddr_a  (nb_raddr_a),
        .nb_raddr_b  (nb_raddr_b),
        .sts         (sts),
        .result      (result)
    );

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg <= '0;
        end
        else if (cfg_we)
        begin
            vertex_count_reg <= cfg_wdata;
        end
    end

    // Output register: load when the walker is done and the slot is free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (sts.done && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sts.done && out_free)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
